>>> src/tws_pkg.sv
package tws_pkg;

   // Command codes carried in the mode field
   typedef enum logic [2:0] {
      MODE_TICK   = 3'd0,
      MODE_WAIT   = 3'd1,
      MODE_SIGNAL = 3'd2,
      MODE_SCHED  = 3'd3,
      MODE_CREATE = 3'd4
   } tws_mode_type;

   // Wait kinds with special meaning
   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_RELEASED  = 3'd1;
   localparam logic [2:0] KIND_SEMAPHORE = 3'd3;

   localparam int IN_BYTES  = 6;
   localparam int OUT_BYTES = 1;

   // Command token handed from cell to cell
   typedef struct packed {
      logic          valid;
      tws_mode_type  mode;
      logic [2:0]    req;
      logic [2:0]    kind;
      logic [15:0]   obj;
      logic [15:0]   amount;
      logic          hit;        // signal: a slot matched; schedule: a slot was picked
      logic [2:0]    idx;        // slot picked by schedule
      logic          rel;        // picked slot was released
      logic          zero_ready; // slot 0 is ready (fallback for schedule)
      logic          zero_rel;   // slot 0 kind was released
   } tws_token_type;

endpackage

>>> src/tws_cell.sv
module tws_cell
   import tws_pkg::*;
#(
   parameter int TASK_SLOTS = 8,
   parameter int INDEX      = 0,
   parameter int TW         = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  tws_token_type tok_in,
   input  logic          clear_sched,
   input  logic [TW-1:0] total,
   output tws_token_type tok_out
);

   localparam logic [TW-1:0] IDX  = TW'(INDEX);
   localparam logic [TW-1:0] LAST = TW'(TASK_SLOTS - 1);
   localparam logic [2:0]    IDX3 = 3'(INDEX);

   logic          active_ff, active_in;
   logic [15:0]   delay_ff, delay_in;
   logic [2:0]    kind_ff, kind_in;
   logic [15:0]   object_ff, object_in;
   tws_token_type tok_out_ff, tok_out_in;
   logic          in_range;

   // Act on the passing command, then hand it on
   always_comb begin
      active_in  = active_ff;
      delay_in   = delay_ff;
      kind_in    = kind_ff;
      object_in  = object_ff;
      tok_out_in = tok_in;
      in_range   = (IDX <= total);
      if (tok_in.valid) begin
         case (tok_in.mode)
            MODE_TICK: begin
               if (in_range && active_ff && delay_ff != 16'd0 && tok_in.amount != 16'd0) begin
                  delay_in = (tok_in.amount >= delay_ff) ? 16'd0 : delay_ff - tok_in.amount;
               end
            end
            MODE_WAIT: begin
               if (32'(tok_in.req) == 32'(INDEX)) begin
                  kind_in   = tok_in.kind;
                  delay_in  = tok_in.amount;
                  object_in = tok_in.obj;
               end
            end
            MODE_SIGNAL: begin
               if (in_range && kind_ff == tok_in.kind && object_ff == tok_in.obj
                   && !(tok_in.kind == KIND_SEMAPHORE && tok_in.hit)) begin
                  kind_in        = KIND_RELEASED;
                  delay_in       = 16'd0;
                  object_in      = 16'd0;
                  tok_out_in.hit = 1'b1;
               end
            end
            MODE_SCHED: begin
               if (in_range && active_ff && delay_ff == 16'd0) begin
                  if (INDEX == 0) begin
                     // slot 0 is checked last; the top level clears it if chosen
                     tok_out_in.zero_ready = 1'b1;
                     tok_out_in.zero_rel   = (kind_ff == KIND_RELEASED);
                  end else if (!tok_in.hit) begin
                     tok_out_in.hit = 1'b1;
                     tok_out_in.idx = IDX3;
                     tok_out_in.rel = (kind_ff == KIND_RELEASED);
                     kind_in        = KIND_NONE;
                     object_in      = 16'd0;
                  end
               end
            end
            MODE_CREATE: begin
               if (total != LAST && IDX == total + TW'(1)) begin
                  active_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (clear_sched) begin
         kind_in   = KIND_NONE;
         object_in = 16'd0;
      end
   end

   // Slot state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= (INDEX == 0);
         delay_ff  <= 16'd0;
         kind_ff   <= KIND_NONE;
         object_ff <= 16'd0;
      end else begin
         active_ff <= active_in;
         delay_ff  <= delay_in;
         kind_ff   <= kind_in;
         object_ff <= object_in;
      end
   end

   // Token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_out_ff <= '0;
      end else begin
         tok_out_ff <= tok_out_in;
      end
   end

   assign tok_out = tok_out_ff;

endmodule

>>> src/task_wait_table_scheduler.sv
// Task-wait table for a small cooperative scheduler.
// Input channel req_*: one command item per handshake (tick, wait set,
// signal, schedule, create). Result channel rsp_*: exactly one result item
// per command, in command order.
// The table is a row of TASK_SLOTS slot cells. An accepted command enters
// cell 0 and moves one cell per clock; each cell updates its own slot as the
// command passes. The result is registered when the command leaves the last
// cell. One command is in the row at a time: the next one can be accepted
// once the previous result is registered, so no new command is taken before
// the last one has left the cell row.
// A result waiting on rsp_ holds steady while rsp_tready is low; a new command
// is accepted while it waits only if it is taken in that same cycle.
// Reset (synchronous, active high) empties the row and the result register,
// marks slot 0 active, clears all other slots and sets the task count to zero.
module task_wait_table_scheduler
   import tws_pkg::*;
#(
   parameter int TASK_SLOTS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // mode[2:0], task_req[5:3], wait_kind[8:6], obj[24:9], amount[40:25], zeros
   input  logic [IN_BYTES*8-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // accepted[0], found[1], task_index[4:2], released[5], zeros
   output logic [OUT_BYTES*8-1:0] rsp_tdata
);

   localparam int TW = $clog2(TASK_SLOTS);
   localparam logic [TW-1:0] LAST = TW'(TASK_SLOTS - 1);

   tws_token_type        tok [TASK_SLOTS+1];
   tws_token_type        tok_head;
   logic                 busy_ff, busy_in;
   logic [TW-1:0]        total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [5:0]           rsp_data_ff, rsp_data_in;
   logic                 clear_zero;
   logic                 accept;
   tws_token_type        done;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy_ff && (!rsp_valid_ff || rsp_tready);

   // Command token into the first cell
   always_comb begin
      tok_head          = '0;
      tok_head.valid    = accept;
      tok_head.mode     = tws_mode_type'(req_tdata[2:0]);
      tok_head.req      = req_tdata[5:3];
      tok_head.kind     = req_tdata[8:6];
      tok_head.obj      = req_tdata[24:9];
      tok_head.amount   = req_tdata[40:25];
   end

   assign tok[0] = tok_head;

   // Row of slot cells
   for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
      tws_cell #(
         .TASK_SLOTS (TASK_SLOTS),
         .INDEX      (i),
         .TW         (TW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .tok_in      (tok[i]),
         .clear_sched ((i == 0) ? clear_zero : 1'b0),
         .total       (total_ff),
         .tok_out     (tok[i+1])
      );
   end

   assign done = tok[TASK_SLOTS];

   // Result assembly as the command leaves the row
   always_comb begin
      busy_in      = busy_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      clear_zero   = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
      if (done.valid) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = 6'b000001;
         case (done.mode)
            MODE_SCHED: begin
               if (done.hit) begin
                  rsp_data_in = {done.rel, done.idx, 1'b1, 1'b1};
               end else if (done.zero_ready) begin
                  rsp_data_in = {done.zero_rel, 3'd0, 1'b1, 1'b1};
                  clear_zero  = 1'b1;
               end
            end
            MODE_CREATE: begin
               if (total_ff == LAST) begin
                  rsp_data_in = 6'b000000;
               end else begin
                  total_in    = total_ff + TW'(1);
                  rsp_data_in = {1'b0, 3'(32'(total_ff) + 1), 1'b0, 1'b1};
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

>>> src/tws_checker.sv
module tws_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Only one command in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command accepted while busy");

   // A result never appears right after a command is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("result appeared too early");

   // A rejected create reports no slot
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> !rsp_tdata[1] && rsp_tdata[4:2] == 3'd0
                                      && !rsp_tdata[5])
      else $error("rejected item carries slot fields");

endmodule

bind task_wait_table_scheduler tws_checker u_tws_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/tb_task_wait_table_scheduler.sv
module tb_task_wait_table_scheduler
   import tws_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TASK_SLOTS   = 8;
   localparam int RANDOM_ITEMS = 1980;
   localparam int CALM_ITEMS   = 200;
   localparam int CYCLE_LIMIT  = 200000;

   // mode codes the block does not define
   localparam logic [2:0] MODE_RSVD5 = 3'd5;
   localparam logic [2:0] MODE_RSVD6 = 3'd6;
   localparam logic [2:0] MODE_RSVD7 = 3'd7;

   // wait kinds not named in the package
   localparam logic [2:0] KIND_TIMEOUT = 3'd2;
   localparam logic [2:0] KIND_EVENT   = 3'd4;
   localparam logic [2:0] KIND_MAIL    = 3'd5;
   localparam logic [2:0] KIND_ODD6    = 3'd6;
   localparam logic [2:0] KIND_ODD7    = 3'd7;

   typedef struct {
      logic [2:0]  mode;
      logic [2:0]  req;
      logic [2:0]  kind;
      logic [15:0] obj;
      logic [15:0] amount;
      bit          calm;
   } command_type;

   typedef struct {
      logic       accepted;
      logic       found;
      logic [2:0] index;
      logic       released;
   } outcome_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // mode[2:0], task_req[5:3], wait_kind[8:6], obj[24:9], amount[40:25], zeros
   logic [IN_BYTES*8-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // accepted[0], found[1], task_index[4:2], released[5], zeros
   logic [OUT_BYTES*8-1:0] rsp_tdata;

   command_type pending_cmds[$];
   outcome_type expected_outcomes[$];

   // shadow of the wait table
   bit          tbl_active[TASK_SLOTS];
   logic [15:0] tbl_delay[TASK_SLOTS];
   logic [2:0]  tbl_kind[TASK_SLOTS];
   logic [15:0] tbl_object[TASK_SLOTS];
   int unsigned tbl_total;

   int unsigned total_items;
   int unsigned items_sent;
   int unsigned results_seen;
   int unsigned errors;
   int unsigned cycles;
   int unsigned picks, picks_released, creates_rejected, signal_releases, idle_scheds;
   bit          calm_phase;

   task_wait_table_scheduler #(.TASK_SLOTS(TASK_SLOTS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5ns clock = ~clock;

   // apply one command to the shadow table, return the result it produces
   function automatic outcome_type table_command(command_type c);
      outcome_type o;
      int unsigned pos;
      bit          done;
      o = '{accepted: 1'b1, found: 1'b0, index: 3'd0, released: 1'b0};
      done = 1'b0;
      pos = 0;
      case (c.mode)
         MODE_TICK: begin
            if (c.amount != 0) begin
               for (int i = 0; i <= tbl_total; i++) begin
                  if (tbl_active[i] && tbl_delay[i] != 0)
                     tbl_delay[i] = (c.amount >= tbl_delay[i]) ? 16'd0 : tbl_delay[i] - c.amount;
               end
            end
         end
         MODE_WAIT: begin
            tbl_kind[c.req]   = c.kind;
            tbl_delay[c.req]  = c.amount;
            tbl_object[c.req] = c.obj;
         end
         MODE_SIGNAL: begin
            // semaphore wakes only the first matching slot
            for (int i = 0; i <= tbl_total; i++) begin
               if (!done && tbl_kind[i] == c.kind && tbl_object[i] == c.obj) begin
                  tbl_kind[i]   = KIND_RELEASED;
                  tbl_delay[i]  = 16'd0;
                  tbl_object[i] = 16'd0;
                  signal_releases++;
                  if (c.kind == KIND_SEMAPHORE) done = 1'b1;
               end
            end
         end
         MODE_SCHED: begin
            // slots 1..total first, slot 0 last
            for (int n = 0; n <= tbl_total; n++) begin
               pos = pos + 1;
               if (pos > tbl_total) pos = 0;
               if (!done && tbl_active[pos] && tbl_delay[pos] == 0) begin
                  done = 1'b1;
                  o.found    = 1'b1;
                  o.index    = pos[2:0];
                  o.released = (tbl_kind[pos] == KIND_RELEASED);
                  tbl_kind[pos]   = KIND_NONE;
                  tbl_object[pos] = 16'd0;
               end
            end
            if (done) begin
               picks++;
               if (o.released) picks_released++;
            end else begin
               idle_scheds++;
            end
         end
         MODE_CREATE: begin
            if (tbl_total >= TASK_SLOTS - 1) begin
               o.accepted = 1'b0;
               creates_rejected++;
            end else begin
               tbl_total = tbl_total + 1;
               tbl_active[tbl_total] = 1'b1;
               o.index = tbl_total[2:0];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic add_cmd(logic [2:0] mode, logic [2:0] req, logic [2:0] kind,
                          logic [15:0] obj, logic [15:0] amount, bit calm);
      command_type c;
      c = '{mode: mode, req: req, kind: kind, obj: obj, amount: amount, calm: calm};
      pending_cmds.push_back(c);
   endtask

   // small pools so that waits and signals actually meet
   function automatic logic [2:0] pick_kind();
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 2))
            0: return KIND_SEMAPHORE;
            1: return KIND_EVENT;
            default: return KIND_MAIL;
         endcase
      end
      return 3'($urandom_range(0, 7));
   endfunction

   function automatic logic [15:0] pick_obj();
      if ($urandom_range(0, 9) < 8) begin
         case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'h8000;
            default: return 16'hffff;
         endcase
      end
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_amount(int zero_pct, int max_small);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return 16'd0;
      if (r < 80) return 16'($urandom_range(1, max_small));
      if (r < 90) return 16'hffff;
      return 16'($urandom);
   endfunction

   // reset once, at the start
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: holds an item until taken, idle bursts between items
   always @(posedge clock) begin
      command_type nxt;
      int unsigned gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(table_command(nxt));
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               // burn idle cycles only where the block could take an item
               if (req_tready || items_sent == results_seen) gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               nxt = pending_cmds.pop_front();
               calm_phase = nxt.calm;
               req_tdata  <= {7'd0, nxt.amount, nxt.obj, nxt.kind, nxt.req, nxt.mode};
               req_tvalid <= 1'b1;
               if (!nxt.calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 5);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: random backpressure, compare each result with the oldest prediction
   always @(posedge clock) begin
      outcome_type exp_o;
      int unsigned stall_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_outcomes.size() == 0) begin
               $display("%0t: result with nothing expected, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               exp_o = expected_outcomes.pop_front();
               if (rsp_tdata[0] !== exp_o.accepted) begin
                  $display("%0t: accepted expected %0d actual %0d",
                           $time, exp_o.accepted, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[1] !== exp_o.found) begin
                  $display("%0t: found expected %0d actual %0d",
                           $time, exp_o.found, rsp_tdata[1]);
                  errors++;
               end
               if (rsp_tdata[4:2] !== exp_o.index) begin
                  $display("%0t: task_index expected %0d actual %0d",
                           $time, exp_o.index, rsp_tdata[4:2]);
                  errors++;
               end
               if (rsp_tdata[5] !== exp_o.released) begin
                  $display("%0t: released expected %0d actual %0d",
                           $time, exp_o.released, rsp_tdata[5]);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm_phase && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 5);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_outcomes.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int r;
      bit calm;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         tbl_active[i] = (i == 0);
         tbl_delay[i]  = 16'd0;
         tbl_kind[i]   = KIND_NONE;
         tbl_object[i] = 16'd0;
      end
      tbl_total = 0;

      // directed: fresh table, odd modes, semaphore vs event, nothing ready
      add_cmd(MODE_SCHED,  3'd0, KIND_NONE,      16'h0000, 16'h0000, 0);
      add_cmd(MODE_RSVD5,  3'd7, KIND_ODD7,      16'hffff, 16'hffff, 0);
      add_cmd(MODE_RSVD6,  3'd0, KIND_NONE,      16'h0000, 16'h0000, 0);
      add_cmd(MODE_RSVD7,  3'd5, KIND_MAIL,      16'h5555, 16'haaaa, 0);
      add_cmd(MODE_TICK,   3'd7, KIND_ODD7,      16'hffff, 16'h0000, 0);
      add_cmd(MODE_CREATE, 3'd0, KIND_NONE,      16'h0000, 16'h0000, 0);
      add_cmd(MODE_CREATE, 3'd7, KIND_ODD7,      16'hffff, 16'hffff, 0);
      add_cmd(MODE_WAIT,   3'd1, KIND_SEMAPHORE, 16'hffff, 16'hffff, 0);
      add_cmd(MODE_WAIT,   3'd2, KIND_SEMAPHORE, 16'hffff, 16'd10,   0);
      add_cmd(MODE_WAIT,   3'd5, KIND_SEMAPHORE, 16'hffff, 16'd0,    0);
      add_cmd(MODE_SCHED,  3'd0, KIND_NONE,      16'h0000, 16'h0000, 0);
      add_cmd(MODE_TICK,   3'd0, KIND_NONE,      16'h0000, 16'd4,    0);
      add_cmd(MODE_SIGNAL, 3'd0, KIND_SEMAPHORE, 16'hffff, 16'h0000, 0);
      add_cmd(MODE_SCHED,  3'd0, KIND_NONE,      16'h0000, 16'h0000, 0);
      add_cmd(MODE_SIGNAL, 3'd0, KIND_SEMAPHORE, 16'hffff, 16'h0000, 0);
      add_cmd(MODE_WAIT,   3'd0, KIND_EVENT,     16'h0000, 16'd3,    0);
      add_cmd(MODE_SIGNAL, 3'd0, KIND_EVENT,     16'h0000, 16'h0000, 0);
      add_cmd(MODE_SIGNAL, 3'd0, KIND_RELEASED,  16'h0000, 16'h0000, 0);
      add_cmd(MODE_WAIT,   3'd1, KIND_ODD7,      16'h1234, 16'd5,    0);
      add_cmd(MODE_WAIT,   3'd2, KIND_ODD6,      16'h0000, 16'd2,    0);
      add_cmd(MODE_WAIT,   3'd0, KIND_NONE,      16'h0000, 16'd9,    0);
      add_cmd(MODE_SCHED,  3'd0, KIND_NONE,      16'h0000, 16'h0000, 0);
      add_cmd(MODE_SIGNAL, 3'd0, KIND_NONE,      16'h0000, 16'h0000, 0);
      add_cmd(MODE_TICK,   3'd0, KIND_NONE,      16'h0000, 16'hffff, 0);
      add_cmd(MODE_SCHED,  3'd0, KIND_NONE,      16'h0000, 16'h0000, 0);

      // random: mostly waits, signals, ticks and schedules on shared objects;
      // creates are rare so the table fills gradually
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
         r = $urandom_range(0, 999);
         if (r < 50)
            add_cmd(3'($urandom), 3'($urandom), 3'($urandom), 16'($urandom),
                    16'($urandom), calm);
         else if (r < 65)
            add_cmd(MODE_CREATE, 3'($urandom), 3'($urandom), 16'($urandom),
                    16'($urandom), calm);
         else if (r < 90)
            add_cmd(3'($urandom_range(MODE_RSVD5, MODE_RSVD7)), 3'($urandom),
                    3'($urandom), 16'($urandom), 16'($urandom), calm);
         else if (r < 290)
            add_cmd(MODE_TICK, 3'($urandom), 3'($urandom), 16'($urandom),
                    pick_amount(10, 20), calm);
         else if (r < 540)
            add_cmd(MODE_WAIT, 3'($urandom), pick_kind(), pick_obj(),
                    pick_amount(40, 30), calm);
         else if (r < 740)
            add_cmd(MODE_SIGNAL, 3'($urandom), pick_kind(), pick_obj(),
                    16'($urandom), calm);
         else
            add_cmd(MODE_SCHED, 3'($urandom), 3'($urandom), 16'($urandom),
                    16'($urandom), calm);
      end
      total_items = pending_cmds.size();

      @(negedge reset);
      while (items_sent < total_items || expected_outcomes.size() != 0) @(posedge clock);
      repeat (2 * (TASK_SLOTS + 1)) @(posedge clock);

      $display("ran %0d commands on a %0d-slot table, %0d schedule picks (%0d released),",
               items_sent, TASK_SLOTS, picks, picks_released);
      $display("%0d empty schedules, %0d slots woken by signal, %0d creates refused",
               idle_scheds, signal_releases, creates_rejected);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
